>>> rtl/core/exs_pkg.sv
// Package for the exchange sort core: default parameters, fixed field widths
// and the sequencer state type. No dependencies.

package exs_pkg;

   localparam int DEF_MAX_COUNT   = 64;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int ORIG_INDEX_WIDTH = 6;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_SCAN,
      ST_TAIL,
      ST_EMIT
   } state_type;

endpackage

>>> rtl/core/exs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. No dependencies.

module exs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

>>> rtl/core/exs_cmp.sv
// Shared compare unit of the exchange sort: flags a swap when the held key
// is strictly greater than the fetched key, both signed. No dependencies.

module exs_cmp #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic [VALUE_WIDTH-1:0] held_key,
   input  logic [VALUE_WIDTH-1:0] fetched_key,
   output logic                   swap
);

   assign swap = $signed(held_key) > $signed(fetched_key);

endmodule

>>> rtl/core/exchange_sort_with_permutation_core.sv
// Top level of the exchange sort core: load sequencer, sort sequencer and
// result emission. Uses exs_pkg, exs_ram and exs_cmp.
//
// Usage. A transaction on the request channel is accepted when start is high
// and busy is low. Each transaction carries one complex value; the one with
// req_last_item set closes the set. Up to MAX_COUNT values are stored; later
// ones are dropped and the overflow flag is raised for that set.
// Loading takes one cycle per transaction and busy stays low while loading.
// After the closing transaction busy goes high while the set of N values is
// sorted by the real part and emitted. The sort keeps the held element at
// position i in a register and streams positions i+1..N-1 through the single
// RAM read port and the shared comparator, one position per cycle. Emission
// then shows one result per cycle on the rsp_ ports, marked by rsp_valid for
// exactly one cycle, the first one once the EMIT state has issued its RAM
// read and the read data and rsp_valid are registered; rsp_last_result marks
// the final one. The receiver cannot stall the results. Busy falls as the
// last RAM read data is registered, so the next set may start loading while
// the last result is shown. Synchronous reset empties the set and clears the
// overflow flag; the RAM needs no clearing.

module exchange_sort_with_permutation_core #(
   parameter int MAX_COUNT   = exs_pkg::DEF_MAX_COUNT,
   parameter int VALUE_WIDTH = exs_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [VALUE_WIDTH-1:0]                req_key_real,
   input  logic [VALUE_WIDTH-1:0]                req_key_imag,
   input  logic                                  req_last_item,
   output logic                                  rsp_valid,
   output logic [VALUE_WIDTH-1:0]                rsp_value_real,
   output logic [VALUE_WIDTH-1:0]                rsp_value_imag,
   output logic [exs_pkg::ORIG_INDEX_WIDTH-1:0]  rsp_original_index,
   output logic                                  rsp_last_result,
   output logic                                  rsp_overflow
);

   localparam int IW = $clog2(MAX_COUNT);
   localparam int CW = $clog2(MAX_COUNT + 1);
   localparam int WW = 2 * VALUE_WIDTH + IW;
   localparam int XW = (IW > exs_pkg::ORIG_INDEX_WIDTH) ? IW : exs_pkg::ORIG_INDEX_WIDTH;

   exs_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic          flag_ff, flag_in;
   logic          emit_valid_ff, emit_valid_in;
   logic          emit_last_ff, emit_last_in;
   logic          emit_ovf_ff, emit_ovf_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] last_addr_ff, last_addr_in;
   logic [WW-1:0] cur_ff, cur_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [WW-1:0] ram_wdata;
   logic          ram_re;
   logic [IW-1:0] ram_raddr;
   logic [WW-1:0] ram_rdata;

   logic          accept;
   logic          full;
   logic          swap;
   logic [XW-1:0] index_ext;

   exs_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_COUNT)
   ) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .re       (ram_re),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   exs_cmp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_cmp (
      .held_key    (cur_ff[VALUE_WIDTH-1:0]),
      .fetched_key (ram_rdata[VALUE_WIDTH-1:0]),
      .swap        (swap)
   );

   assign busy   = (state_ff != exs_pkg::ST_LOAD);
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(MAX_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= exs_pkg::ST_LOAD;
         count_ff      <= '0;
         flag_ff       <= 1'b0;
         emit_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         flag_ff       <= flag_in;
         emit_valid_ff <= emit_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      last_addr_ff <= last_addr_in;
      cur_ff       <= cur_in;
      emit_last_ff <= emit_last_in;
      emit_ovf_ff  <= emit_ovf_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      flag_in       = flag_ff;
      emit_valid_in = 1'b0;
      emit_last_in  = emit_last_ff;
      emit_ovf_in   = emit_ovf_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      last_addr_in  = last_addr_ff;
      cur_in        = cur_ff;
      ram_we        = 1'b0;
      ram_waddr     = i_ff;
      ram_wdata     = cur_ff;
      ram_re        = 1'b0;
      ram_raddr     = i_ff;

      case (state_ff)
         exs_pkg::ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  flag_in = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[IW-1:0];
                  ram_wdata = {count_ff[IW-1:0], req_key_imag, req_key_real};
                  count_in  = count_ff + CW'(1);
               end
               if (req_last_item) begin
                  last_addr_in = full ? IW'(MAX_COUNT - 1) : count_ff[IW-1:0];
                  i_in         = '0;
                  k_in         = '0;
                  if (!full && count_ff == '0) begin
                     state_in = exs_pkg::ST_EMIT;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                     state_in  = exs_pkg::ST_FETCH;
                  end
               end
            end
         end
         exs_pkg::ST_FETCH: begin
            cur_in    = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = i_ff + IW'(1);
            j_in      = i_ff + IW'(1);
            state_in  = exs_pkg::ST_SCAN;
         end
         exs_pkg::ST_SCAN: begin
            if (swap) begin
               ram_we    = 1'b1;
               ram_waddr = j_ff;
               ram_wdata = cur_ff;
               cur_in    = ram_rdata;
            end
            if (j_ff == last_addr_ff) begin
               state_in = exs_pkg::ST_TAIL;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = j_ff + IW'(1);
               j_in      = j_ff + IW'(1);
            end
         end
         exs_pkg::ST_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = cur_ff;
            if (i_ff + IW'(1) == last_addr_ff) begin
               state_in = exs_pkg::ST_EMIT;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = i_ff + IW'(1);
               i_in      = i_ff + IW'(1);
               state_in  = exs_pkg::ST_FETCH;
            end
         end
         exs_pkg::ST_EMIT: begin
            ram_re        = 1'b1;
            ram_raddr     = k_ff;
            emit_valid_in = 1'b1;
            emit_last_in  = (k_ff == last_addr_ff);
            emit_ovf_in   = flag_ff;
            if (k_ff == last_addr_ff) begin
               count_in = '0;
               flag_in  = 1'b0;
               state_in = exs_pkg::ST_LOAD;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         default: begin
            state_in = exs_pkg::ST_LOAD;
         end
      endcase
   end

   assign index_ext          = XW'(ram_rdata[WW-1 -: IW]);
   assign rsp_valid          = emit_valid_ff;
   assign rsp_value_real     = ram_rdata[VALUE_WIDTH-1:0];
   assign rsp_value_imag     = ram_rdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
   assign rsp_original_index = index_ext[exs_pkg::ORIG_INDEX_WIDTH-1:0];
   assign rsp_last_result    = emit_last_ff;
   assign rsp_overflow       = emit_ovf_ff;

endmodule
